FILE: src/assert_macros.svh
// assertion macros for the hash map modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, switched off while reset is high
`define CHM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hash map assertion failed");

// checked property, live during reset too
`define CHM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("hash map assertion failed");

`endif

FILE: src/chm_pkg.sv
// types and codes of the chained hash map
// no dependencies
package chm_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 3;
   localparam int ENTRY_W  = 11;
   localparam int BKT_W    = 9;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

   localparam logic [BKT_W-1:0] BUCKET_COUNT_RESET = 9'd251;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic [BKT_W-1:0] bucket;
   } req_item_type;

endpackage

FILE: src/chm_front.sv
// front end: takes requests, hashes the key by iterative modulo
// depends on chm_pkg
module chm_front import chm_pkg::*; #(
   parameter int MAX_BUCKETS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               init_done,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [71:0]        req_tdata,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [BKT_W-1:0]   csr_data,
   output logic               q_valid,
   input  logic               q_ready,
   output req_item_type       q_item
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [BKT_W-1:0] bucket_count_ff;
   logic [OP_W-1:0]  op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic [KEY_W-1:0] mag_ff, mag_in;
   logic [BKT_W-1:0] rem_ff, rem_in;
   logic [BKT_W-1:0] div_ff, div_use;
   logic [2:0]       step_ff;
   logic             accept;

   assign csr_ready  = 1'b1;
   assign req_tready = init_done && (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (bucket_count_ff == '0) begin
         div_use = BKT_W'(1);
      end else if (32'(bucket_count_ff) > MAX_BUCKETS) begin
         div_use = BKT_W'(MAX_BUCKETS);
      end else begin
         div_use = bucket_count_ff;
      end
   end

   // four restoring remainder steps per cycle
   always_comb begin
      logic [BKT_W:0]   t;
      logic [BKT_W-1:0] r;
      logic [KEY_W-1:0] m;
      r = rem_ff;
      m = mag_ff;
      for (int i = 0; i < 4; i++) begin
         t = {r, m[KEY_W-1]};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
         end
         r = t[BKT_W-1:0];
         m = {m[KEY_W-2:0], 1'b0};
      end
      rem_in = r;
      mag_in = m;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            if (step_ff == 3'd7) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (q_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= F_IDLE;
         bucket_count_ff <= BUCKET_COUNT_RESET;
         step_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            bucket_count_ff <= csr_data;
         end
         if (state_ff == F_DIV) begin
            step_ff <= step_ff + 3'd1;
         end else begin
            step_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_tdata[1:0];
         key_ff   <= req_tdata[33:2];
         value_ff <= req_tdata[65:34];
         div_ff   <= div_use;
         rem_ff   <= '0;
         mag_ff   <= req_tdata[33] ? (~req_tdata[33:2] + 32'd1) : req_tdata[33:2];
      end else if (state_ff == F_DIV) begin
         rem_ff <= rem_in;
         mag_ff <= mag_in;
      end
   end

   // negative key with a nonzero remainder folds back into range
   assign q_valid      = (state_ff == F_PUSH);
   assign q_item.op    = op_ff;
   assign q_item.key   = key_ff;
   assign q_item.value = value_ff;
   assign q_item.bucket = (key_ff[KEY_W-1] && (rem_ff != '0)) ? (div_ff - rem_ff) : rem_ff;

endmodule

FILE: src/chm_queue.sv
// two-entry queue between hash front end and chain engine
// depends on chm_pkg
module chm_queue import chm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output req_item_type out_item
);

   req_item_type mem_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

FILE: src/chm_back.sv
// chain engine: bucket heads, node pool, free list, result register
// depends on chm_pkg and assert_macros.svh
`include "assert_macros.svh"
module chm_back import chm_pkg::*; #(
   parameter int MAX_BUCKETS = 256,
   parameter int POOL_NODES  = 1024
) (
   input  logic         clock,
   input  logic         reset,
   output logic         init_done,
   input  logic         q_valid,
   output logic         q_pop,
   input  req_item_type q_item,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata
);

   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int NW = $clog2(POOL_NODES);
   localparam int PW = $clog2(POOL_NODES + 1);
   localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

   localparam logic [3:0] B_CLEAR = 4'd0;
   localparam logic [3:0] B_IDLE  = 4'd1;
   localparam logic [3:0] B_HEAD  = 4'd2;
   localparam logic [3:0] B_CHK   = 4'd3;
   localparam logic [3:0] B_CMP   = 4'd4;
   localparam logic [3:0] B_MISS  = 4'd5;
   localparam logic [3:0] B_FRD   = 4'd6;
   localparam logic [3:0] B_ALLOC = 4'd7;
   localparam logic [3:0] B_DEL2  = 4'd8;

   logic [PW-1:0]    heads_mem  [MAX_BUCKETS];
   logic [KEY_W-1:0] keys_mem   [POOL_NODES];
   logic [VAL_W-1:0] values_mem [POOL_NODES];
   logic [PW-1:0]    links_mem  [POOL_NODES];

   logic [3:0]       state_ff, state_in;
   logic [BW-1:0]    clr_ff, clr_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [BW-1:0]    bucket_ff, bucket_in;
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    cur_ff, cur_in;
   logic [PW-1:0]    prev_ff, prev_in;
   logic [PW-1:0]    steps_ff, steps_in;
   logic [PW-1:0]    node_ff, node_in;
   logic             from_free_ff, from_free_in;
   logic [PW-1:0]    free_head_ff, free_head_in;
   logic [PW-1:0]    next_unused_ff, next_unused_in;
   logic [PW-1:0]    count_ff, count_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VAL_W-1:0]    rsp_found_ff;
   logic [ENTRY_W-1:0]  rsp_count_ff;

   logic [PW-1:0]    head_q;
   logic [KEY_W-1:0] key_q;
   logic [VAL_W-1:0] value_q;
   logic [PW-1:0]    link_q;

   logic                load;
   logic [STATUS_W-1:0] load_status;
   logic [VAL_W-1:0]    load_found;
   logic                head_we, link_we, node_we, value_we;
   logic [BW-1:0]       head_waddr;
   logic [PW-1:0]       head_wdata, link_wdata;
   logic [NW-1:0]       link_waddr, value_waddr;

   assign init_done = (state_ff != B_CLEAR);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      bucket_in      = bucket_ff;
      head_in        = head_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      steps_in       = steps_ff;
      node_in        = node_ff;
      from_free_in   = from_free_ff;
      free_head_in   = free_head_ff;
      next_unused_in = next_unused_ff;
      count_in       = count_ff;
      q_pop          = 1'b0;
      load           = 1'b0;
      load_status    = ST_NOTFOUND;
      load_found     = '0;
      head_we        = 1'b0;
      head_waddr     = bucket_ff;
      head_wdata     = NIL;
      link_we        = 1'b0;
      link_waddr     = cur_ff[NW-1:0];
      link_wdata     = free_head_ff;
      node_we        = 1'b0;
      value_we       = 1'b0;
      value_waddr    = node_ff[NW-1:0];
      unique case (state_ff)
         B_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = NIL;
            if (clr_ff == BW'(MAX_BUCKETS - 1)) begin
               state_in = B_IDLE;
            end else begin
               clr_in = clr_ff + BW'(1);
            end
         end
         B_IDLE: begin
            if (q_valid && (!rsp_valid_ff || rsp_tready)) begin
               q_pop     = 1'b1;
               op_in     = q_item.op;
               key_in    = q_item.key;
               value_in  = q_item.value;
               bucket_in = BW'(q_item.bucket);
               if ((q_item.op == OP_INSERT) || (q_item.op == OP_SEARCH) ||
                   (q_item.op == OP_DELETE)) begin
                  state_in = B_HEAD;
               end else begin
                  load = 1'b1;
               end
            end
         end
         B_HEAD: begin
            head_in  = head_q;
            cur_in   = head_q;
            prev_in  = NIL;
            steps_in = '0;
            state_in = B_CHK;
         end
         B_CHK: begin
            if ((cur_ff >= NIL) || (steps_ff == NIL)) begin
               state_in = B_MISS;
            end else begin
               state_in = B_CMP;
            end
         end
         B_CMP: begin
            if (key_q == key_ff) begin
               unique case (op_ff)
                  OP_INSERT: begin
                     value_we    = 1'b1;
                     value_waddr = cur_ff[NW-1:0];
                     load        = 1'b1;
                     load_status = ST_UPDATED;
                     state_in    = B_IDLE;
                  end
                  OP_SEARCH: begin
                     load        = 1'b1;
                     load_status = ST_FOUND;
                     load_found  = value_q;
                     state_in    = B_IDLE;
                  end
                  OP_DELETE: begin
                     if (prev_ff != NIL) begin
                        link_we    = 1'b1;
                        link_waddr = prev_ff[NW-1:0];
                        link_wdata = link_q;
                     end else begin
                        head_we    = 1'b1;
                        head_waddr = bucket_ff;
                        head_wdata = link_q;
                     end
                     state_in = B_DEL2;
                  end
                  default: begin
                     load     = 1'b1;
                     state_in = B_IDLE;
                  end
               endcase
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_q;
               steps_in = steps_ff + PW'(1);
               state_in = B_CHK;
            end
         end
         B_DEL2: begin
            link_we      = 1'b1;
            link_waddr   = cur_ff[NW-1:0];
            link_wdata   = free_head_ff;
            free_head_in = cur_ff;
            if (count_ff != '0) begin
               count_in = count_ff - PW'(1);
            end
            load        = 1'b1;
            load_status = ST_DELETED;
            state_in    = B_IDLE;
         end
         B_MISS: begin
            if (op_ff == OP_INSERT) begin
               if (free_head_ff != NIL) begin
                  cur_in       = free_head_ff;
                  node_in      = free_head_ff;
                  from_free_in = 1'b1;
                  state_in     = B_FRD;
               end else if (next_unused_ff < NIL) begin
                  node_in        = next_unused_ff;
                  next_unused_in = next_unused_ff + PW'(1);
                  from_free_in   = 1'b0;
                  state_in       = B_ALLOC;
               end else begin
                  load        = 1'b1;
                  load_status = ST_FULL;
                  state_in    = B_IDLE;
               end
            end else begin
               load     = 1'b1;
               state_in = B_IDLE;
            end
         end
         B_FRD: begin
            state_in = B_ALLOC;
         end
         B_ALLOC: begin
            node_we     = 1'b1;
            value_we    = 1'b1;
            value_waddr = node_ff[NW-1:0];
            link_we     = 1'b1;
            link_waddr  = node_ff[NW-1:0];
            link_wdata  = head_ff;
            head_we     = 1'b1;
            head_waddr  = bucket_ff;
            head_wdata  = node_ff;
            if (from_free_ff) begin
               free_head_in = link_q;
            end
            count_in    = count_ff + PW'(1);
            load        = 1'b1;
            load_status = ST_INSERTED;
            state_in    = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_CLEAR;
         clr_ff         <= '0;
         free_head_ff   <= NIL;
         next_unused_ff <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         free_head_ff   <= free_head_in;
         next_unused_ff <= next_unused_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= load || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      bucket_ff    <= bucket_in;
      head_ff      <= head_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      steps_ff     <= steps_in;
      node_ff      <= node_in;
      from_free_ff <= from_free_in;
      if (load) begin
         rsp_status_ff <= load_status;
         rsp_found_ff  <= load_found;
         rsp_count_ff  <= ENTRY_W'(count_in);
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (head_we) begin
         heads_mem[head_waddr] <= head_wdata;
      end
      head_q <= heads_mem[BW'(q_item.bucket)];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         keys_mem[node_ff[NW-1:0]] <= key_ff;
      end
      if (value_we) begin
         values_mem[value_waddr] <= value_ff;
      end
      if (link_we) begin
         links_mem[link_waddr] <= link_wdata;
      end
      key_q   <= keys_mem[cur_ff[NW-1:0]];
      value_q <= values_mem[cur_ff[NW-1:0]];
      link_q  <= links_mem[cur_ff[NW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_found_ff, rsp_status_ff};

   `CHM_ASSERT(a_count_bound, clock, reset, count_ff <= NIL)
   `CHM_ASSERT(a_pop_idle, clock, reset, q_pop |-> (state_ff == B_IDLE))
   `CHM_ASSERT(a_rsp_free, clock, reset, load |-> (!rsp_valid_ff || rsp_tready))
   `CHM_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> (state_ff == B_CLEAR))

endmodule

FILE: src/chained_hash_map_division.sv
// top level of the chained hash map with division hash
// depends on chm_pkg, chm_front, chm_queue, chm_back
//
//   channel  dir  signals                        content
//   req      in   req_tvalid/tready/tdata[71:0]  op, key, value
//   rsp      out  rsp_tvalid/tready/tdata[47:0]  status, found_value, entry_count
//   csr      in   csr_valid/ready/data[8:0]      bucket_count, always ready
//
// a request passes through the front divider (four remainder bits a cycle),
// then the chain engine reads the bucket head, checks and compares each node passed
// over, then unlinks and frees a node or places a new one (reading a freed one's link first)
// after reset the engine writes every bucket head to null, and no request beat
// is taken during that pass
// a two-entry queue parts hashing from the chain walk; the engine pops the next
// request only once the result register is empty or its beat leaves that cycle
module chained_hash_map_division import chm_pkg::*; #(
   parameter int MAX_BUCKETS = 256,
   parameter int POOL_NODES  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request: [1:0] op, [33:2] key, [65:34] value, rest zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // result: [2:0] status, [34:3] found_value, [45:35] entry_count, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // bucket count register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);

   req_item_type fq_item, qb_item;
   logic         fq_valid, fq_ready;
   logic         qb_valid, qb_pop;
   logic         init_done;

   // hashing front end, holds the bucket count register
   chm_front #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .init_done  (init_done),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_valid    (fq_valid),
      .q_ready    (fq_ready),
      .q_item     (fq_item)
   );

   // hashed requests waiting for the chain engine
   chm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_pop),
      .out_item  (qb_item)
   );

   // chain walk, pool management and result beat
   chm_back #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .POOL_NODES  (POOL_NODES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .init_done  (init_done),
      .q_valid    (qb_valid),
      .q_pop      (qb_pop),
      .q_item     (qb_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
